@@ hw/rtl/spur_pkg.sv @@
// Shared types and constants of the subpicture unit reframer.
package spur_pkg;

    localparam int BYTE_W          = 8;
    localparam int PTS_W           = 33;
    localparam int LEN_W           = 16;
    localparam int STAMP_BYTES     = 8;
    localparam int STAMP_W         = STAMP_BYTES * BYTE_W;
    localparam int STAMP_CNT_W     = $clog2(STAMP_BYTES + 1);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [LEN_W-1:0] LEN_MIN = 16'd2;

    // Command kinds handed from the front to the back.
    localparam logic [1:0] CMD_STAMP = 2'd0;  // timestamp then the byte
    localparam logic [1:0] CMD_PASS  = 2'd1;  // the byte alone
    localparam logic [1:0] CMD_ERR   = 2'd2;  // the byte alone, flagged

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic [PTS_W-1:0]  pts;
    } spur_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spur_q_stat_t;

endpackage

@@ hw/rtl/spur_ifs.sv @@
// Channel interfaces: packet bytes in, reframed unit bytes out.
interface spur_in_if;
    import spur_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_end;
    logic [PTS_W-1:0]  packet_pts;

    modport source (output valid, output payload_byte, output packet_end,
                    output packet_pts, input ready);
    modport sink   (input valid, input payload_byte, input packet_end,
                    input packet_pts, output ready);
endinterface

interface spur_out_if;
    import spur_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_stamp;
    logic              run_last;
    logic              length_error;

    modport source (output valid, output out_byte, output is_stamp,
                    output run_last, output length_error, input ready);
    modport sink   (input valid, input out_byte, input is_stamp,
                    input run_last, input length_error, output ready);
endinterface

@@ hw/rtl/spur_front.sv @@
// Front: accepts packet bytes, tracks the unit length and issues commands.
module spur_front
    import spur_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    spur_in_if.sink      packet,
    input  spur_q_stat_t q_stat,
    output logic         push,
    output spur_cmd_t    cmd
);

    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_PASS = 2'd2;
    localparam logic [1:0] PH_DROP = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] length_high_reg, length_high_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;

    logic             accept;
    logic             len_small;
    logic [LEN_W-1:0] len_rem;
    logic [LEN_W-1:0] left_dec;

    assign packet.ready = !q_stat.full;
    assign accept       = packet.valid && packet.ready;

    assign len_small = (length_high_reg == '0) && (packet.payload_byte[BYTE_W-1:1] == '0);
    assign len_rem   = {length_high_reg, packet.payload_byte} - LEN_MIN;
    assign left_dec  = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        bytes_left_next  = bytes_left_reg;
        push             = 1'b0;
        cmd.kind         = CMD_PASS;
        cmd.data         = packet.payload_byte;
        cmd.pts          = packet.packet_pts;
        unique case (phase_reg)
            PH_HIGH:
            begin
                push     = accept;
                cmd.kind = CMD_STAMP;
                if (accept)
                begin
                    length_high_next = packet.payload_byte;
                    phase_next       = PH_LOW;
                end
            end
            PH_LOW:
            begin
                push = accept;
                if (len_small)
                begin
                    cmd.kind = CMD_ERR;
                    if (accept)
                    begin
                        bytes_left_next  = '0;
                        length_high_next = '0;
                        phase_next       = packet.packet_end ? PH_HIGH : PH_DROP;
                    end
                end
                else if (accept)
                begin
                    bytes_left_next = len_rem;
                    phase_next      = (len_rem == '0) ? PH_HIGH : PH_PASS;
                end
            end
            PH_PASS:
            begin
                push = accept;
                if (accept)
                begin
                    bytes_left_next = left_dec;
                    if (left_dec == '0)
                        phase_next = PH_HIGH;
                end
            end
            PH_DROP:
            begin
                // drop bytes up to and including the packet end
                if (accept && packet.packet_end)
                    phase_next = PH_HIGH;
            end
            default:
            begin
                phase_next = PH_HIGH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HIGH;
            length_high_reg <= '0;
            bytes_left_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    // A unit in progress always has bytes left to pass.
    a_pass_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PASS) |-> (bytes_left_reg != '0))
        else $error("passing phase with no bytes left");

    // After a length error the held length is cleared.
    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.kind == CMD_ERR) |=> (length_high_reg == '0 && bytes_left_reg == '0))
        else $error("length state not cleared after error");

    // Nothing is issued while dropping.
    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DROP) |-> !push)
        else $error("command issued while dropping");

endmodule

@@ hw/rtl/spur_cmd_queue.sv @@
// Short command queue between the front and the back.
module spur_cmd_queue
    import spur_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  spur_cmd_t    push_cmd,
    input  logic         pop,
    output spur_cmd_t    head_cmd,
    output spur_q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    spur_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

@@ hw/rtl/spur_back.sv @@
// Back: expands commands into result bytes through an output register.
module spur_back
    import spur_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  spur_cmd_t    head_cmd,
    input  spur_q_stat_t q_stat,
    output logic         pop,
    spur_out_if.source   unit
);

    logic [STAMP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic                   is_stamp_reg;
    logic                   run_last_reg;
    logic                   length_error_reg;

    logic                   load;
    logic                   stamp_step;
    logic [2:0]             byte_idx;
    logic [STAMP_W-1:0]     pts_wide;
    logic [BYTE_W-1:0]      stamp_byte;

    assign load       = !q_stat.empty && (!out_valid_reg || unit.ready);
    assign stamp_step = (head_cmd.kind == CMD_STAMP) &&
                        (cnt_reg < STAMP_CNT_W'(STAMP_BYTES));
    assign pop        = load && !stamp_step;

    // Timestamp goes out most significant byte first.
    assign byte_idx   = 3'(STAMP_BYTES - 1) - cnt_reg[2:0];
    assign pts_wide   = {{(STAMP_W - PTS_W){1'b0}}, head_cmd.pts};
    assign stamp_byte = pts_wide[{byte_idx, 3'b000} +: BYTE_W];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
            cnt_next = stamp_step ? cnt_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (unit.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg     <= stamp_step ? stamp_byte : head_cmd.data;
            is_stamp_reg     <= stamp_step;
            run_last_reg     <= !stamp_step;
            length_error_reg <= !stamp_step && (head_cmd.kind == CMD_ERR);
        end
    end

    assign unit.valid        = out_valid_reg;
    assign unit.out_byte     = out_byte_reg;
    assign unit.is_stamp     = is_stamp_reg;
    assign unit.run_last     = run_last_reg;
    assign unit.length_error = length_error_reg;

    // A partly emitted timestamp always belongs to a waiting stamp command.
    a_cnt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (!q_stat.empty && head_cmd.kind == CMD_STAMP
                             && cnt_reg <= STAMP_CNT_W'(STAMP_BYTES)))
        else $error("stamp counter without stamp command");

endmodule

@@ hw/rtl/subpicture_unit_reframer.sv @@
// Top level of the subpicture unit reframer: front, command queue and back.
// An accepted byte is registered in the command queue, then in the output register.
// Throughput: one input byte per cycle while the queue has room; a unit start yields
//   nine output transactions (eight timestamp bytes, then the high length byte), so
//   the output side sets the pace then and the command queue absorbs the burst.
// Reset: rst_n clears the phase, held length, counters, queue and output
//   valid at once; the block takes transactions right after release.
module subpicture_unit_reframer
    import spur_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    spur_in_if.sink    packet,
    spur_out_if.source unit
);

    // Front to queue: one command per byte that produces results.
    logic         push;
    spur_cmd_t    push_cmd;

    // Queue to back: head command and queue status.
    logic         pop;
    spur_cmd_t    head_cmd;
    spur_q_stat_t q_stat;

    // Classify each incoming transaction; hold the input while the queue is full.
    spur_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet),
        .q_stat (q_stat),
        .push   (push),
        .cmd    (push_cmd)
    );

    // Decouple classification from the variable-length output bursts.
    spur_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // Expand each command into output transactions; advance on output ready.
    spur_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .unit     (unit)
    );

endmodule
